/* src/opg_pkg.sv */
// Shared types, widths and constants of the orbit pointer geometry block.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps
`default_nettype none

package opg_pkg;

    localparam int POS_W         = 24;   // Q15.8 coordinate
    localparam int HEAD_W        = 16;   // heading in 1/128 degree
    localparam int RAD_W         = 24;   // Q16.8 radius
    localparam int DIFF_W        = POS_W + 1;
    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 32;
    localparam int NSTG          = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN :
                                   ((CORDIC_STAGES < 0) ? 0 : CORDIC_STAGES);
    localparam int STG_W         = $clog2(TABLE_LEN);
    localparam int VW            = 44;   // vectoring x/y, difference scaled by 2^16
    localparam int RW            = 43;   // rotation x/y in Q.24
    localparam int ZW            = 27;   // angle in 2^-16 degree
    localparam int GAIN_W        = 31;
    localparam int VEC_SHIFT     = 16;
    localparam int GAIN_SHIFT    = 15;
    localparam int OUT_SHIFT     = 16;
    localparam int HEAD_SHIFT    = 9;

    localparam logic [GAIN_W-1:0] GAIN_Q31 = 31'd1304065748;
    localparam int HALF_TURN = 180 * 65536;
    localparam int HEAD_MAX  = 23040;
    localparam int POS_MAX   = 8388607;
    localparam int POS_MIN   = -8388608;
    localparam int RADIUS_RESET = 38400;

    typedef struct packed {
        logic signed [VW-1:0]    x;
        logic signed [VW-1:0]    y;
        logic signed [ZW-1:0]    z;
        logic signed [RW-1:0]    rx;
        logic signed [RW-1:0]    ry;
        logic signed [POS_W-1:0] cx;
        logic signed [POS_W-1:0] cy;
        logic                    flip;
        logic                    zero;
    } cordic_t;

    // atan(2^-i) in degrees scaled by 2^16, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_lut(input logic [STG_W-1:0] idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            5'd0:    v = 27'sd2949120;
            5'd1:    v = 27'sd1740967;
            5'd2:    v = 27'sd919879;
            5'd3:    v = 27'sd466945;
            5'd4:    v = 27'sd234379;
            5'd5:    v = 27'sd117304;
            5'd6:    v = 27'sd58666;
            5'd7:    v = 27'sd29335;
            5'd8:    v = 27'sd14668;
            5'd9:    v = 27'sd7334;
            5'd10:   v = 27'sd3667;
            5'd11:   v = 27'sd1833;
            5'd12:   v = 27'sd917;
            5'd13:   v = 27'sd458;
            5'd14:   v = 27'sd229;
            5'd15:   v = 27'sd115;
            5'd16:   v = 27'sd57;
            5'd17:   v = 27'sd29;
            5'd18:   v = 27'sd14;
            5'd19:   v = 27'sd7;
            5'd20:   v = 27'sd4;
            5'd21:   v = 27'sd2;
            5'd22:   v = 27'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* src/opg_in_if.sv */
// Input channel of the orbit pointer geometry block: centre and target point.
// Depends on opg_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface opg_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [opg_pkg::POS_W-1:0] center_x;
    logic signed [opg_pkg::POS_W-1:0] center_y;
    logic signed [opg_pkg::POS_W-1:0] goal_x;
    logic signed [opg_pkg::POS_W-1:0] goal_y;

    modport source (output valid, center_x, center_y, goal_x, goal_y, input ready);
    modport sink   (input valid, center_x, center_y, goal_x, goal_y, output ready);
endinterface

`default_nettype wire

/* src/opg_out_if.sv */
// Output channel of the orbit pointer geometry block: pointer position and heading.
// Depends on opg_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface opg_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [opg_pkg::POS_W-1:0]  pointer_x;
    logic signed [opg_pkg::POS_W-1:0]  pointer_y;
    logic signed [opg_pkg::HEAD_W-1:0] heading;

    modport source (output valid, pointer_x, pointer_y, heading, input ready);
    modport sink   (input valid, pointer_x, pointer_y, heading, output ready);
endinterface

`default_nettype wire

/* src/opg_front.sv */
// Front end: difference vector, radius-times-gain product, half-turn folding.
// Two registered stages with a local handshake; depends on opg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module opg_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             up_valid,
    output logic                                  up_ready,
    input  wire logic signed [opg_pkg::POS_W-1:0] center_x,
    input  wire logic signed [opg_pkg::POS_W-1:0] center_y,
    input  wire logic signed [opg_pkg::POS_W-1:0] goal_x,
    input  wire logic signed [opg_pkg::POS_W-1:0] goal_y,
    input  wire logic        [opg_pkg::RAD_W-1:0] radius,
    output logic                                  dn_valid,
    input  wire logic                             dn_ready,
    output opg_pkg::cordic_t                      dn_data
);
    import opg_pkg::*;

    localparam int PROD_W = RAD_W + GAIN_W;

    logic                     s0_valid_reg;
    logic                     s1_valid_reg;
    logic                     s0_ready;
    logic                     s1_ready;
    logic signed [POS_W-1:0]  cx_reg;
    logic signed [POS_W-1:0]  cy_reg;
    logic signed [DIFF_W-1:0] dx_reg;
    logic signed [DIFF_W-1:0] dy_reg;
    logic signed [RW-1:0]     rot0_reg;
    logic signed [DIFF_W-1:0] dx_next;
    logic signed [DIFF_W-1:0] dy_next;
    logic        [PROD_W-1:0] prod;
    logic signed [DIFF_W-1:0] adx;
    logic signed [DIFF_W-1:0] ady;
    cordic_t                  s1_next;
    cordic_t                  s1_reg;

    assign s1_ready = !s1_valid_reg || dn_ready;
    assign s0_ready = !s0_valid_reg || s1_ready;
    assign up_ready = s0_ready;
    assign dn_valid = s1_valid_reg;
    assign dn_data  = s1_reg;

    always_comb
    begin
        dx_next = DIFF_W'(goal_x) - DIFF_W'(center_x);
        dy_next = DIFF_W'(goal_y) - DIFF_W'(center_y);
        prod    = PROD_W'(radius) * PROD_W'(GAIN_Q31);
    end

    // fold the left half plane onto the right one
    always_comb
    begin
        adx = dx_reg[DIFF_W-1] ? -dx_reg : dx_reg;
        ady = dx_reg[DIFF_W-1] ? -dy_reg : dy_reg;
        s1_next.x    = VW'(adx) <<< VEC_SHIFT;
        s1_next.y    = VW'(ady) <<< VEC_SHIFT;
        s1_next.z    = '0;
        if (dx_reg[DIFF_W-1])
        begin
            s1_next.z = dy_reg[DIFF_W-1] ? -ZW'(HALF_TURN) : ZW'(HALF_TURN);
        end
        s1_next.rx   = rot0_reg;
        s1_next.ry   = '0;
        s1_next.cx   = cx_reg;
        s1_next.cy   = cy_reg;
        s1_next.flip = dx_reg[DIFF_W-1];
        s1_next.zero = (dx_reg == '0) && (dy_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (s0_ready)
            begin
                s0_valid_reg <= up_valid;
            end
            if (s1_ready)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_ready && up_valid)
        begin
            cx_reg   <= center_x;
            cy_reg   <= center_y;
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            rot0_reg <= RW'(prod >> GAIN_SHIFT);
        end
        if (s1_ready && s0_valid_reg)
        begin
            s1_reg <= s1_next;
        end
    end

endmodule

`default_nettype wire

/* src/opg_cell.sv */
// One CORDIC cell: vectoring decision and the matching rotation step.
// Registered, with a local handshake; depends on opg_pkg for the atan table.
`timescale 1ns / 1ps
`default_nettype none

module opg_cell (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [opg_pkg::STG_W-1:0] stage,
    input  wire logic                     up_valid,
    output logic                          up_ready,
    input  wire opg_pkg::cordic_t         up_data,
    output logic                          dn_valid,
    input  wire logic                     dn_ready,
    output opg_pkg::cordic_t              dn_data
);
    import opg_pkg::*;

    logic                 valid_reg;
    cordic_t              data_reg;
    cordic_t              data_next;
    logic signed [VW-1:0] xs;
    logic signed [VW-1:0] ys;
    logic signed [RW-1:0] rxs;
    logic signed [RW-1:0] rys;
    logic signed [ZW-1:0] ang;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb
    begin
        xs  = up_data.x >>> stage;
        ys  = up_data.y >>> stage;
        rxs = up_data.rx >>> stage;
        rys = up_data.ry >>> stage;
        ang = atan_lut(stage);
        data_next = up_data;
        // y not negative: turn clockwise, rotate the radius vector counterclockwise
        if (!up_data.y[VW-1])
        begin
            data_next.x  = up_data.x + ys;
            data_next.y  = up_data.y - xs;
            data_next.z  = up_data.z + ang;
            data_next.rx = up_data.rx - rys;
            data_next.ry = up_data.ry + rxs;
        end
        else
        begin
            data_next.x  = up_data.x - ys;
            data_next.y  = up_data.y + xs;
            data_next.z  = up_data.z - ang;
            data_next.rx = up_data.rx + rys;
            data_next.ry = up_data.ry - rxs;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

/* src/opg_back.sv */
// Back end: unfold, round and clamp the heading, add the offset, saturate.
// Two registered stages, the second is the output register; depends on opg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module opg_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              up_valid,
    output logic                                   up_ready,
    input  wire opg_pkg::cordic_t                  up_data,
    input  wire logic        [opg_pkg::RAD_W-1:0]  radius,
    output logic                                   dn_valid,
    input  wire logic                              dn_ready,
    output logic signed      [opg_pkg::POS_W-1:0]  pointer_x,
    output logic signed      [opg_pkg::POS_W-1:0]  pointer_y,
    output logic signed      [opg_pkg::HEAD_W-1:0] heading
);
    import opg_pkg::*;

    localparam int OW = RW - OUT_SHIFT;
    localparam int HW = ZW - HEAD_SHIFT;
    localparam int SW = OW + 1;

    logic                    p1_valid_reg;
    logic                    p2_valid_reg;
    logic                    p1_ready;
    logic                    p2_ready;
    logic signed [RW-1:0]    vx;
    logic signed [RW-1:0]    vy;
    logic signed [ZW-1:0]    zr;
    logic signed [OW-1:0]    offx_next;
    logic signed [OW-1:0]    offy_next;
    logic signed [HW-1:0]    head_next;
    logic signed [OW-1:0]    offx_reg;
    logic signed [OW-1:0]    offy_reg;
    logic signed [HW-1:0]    head_reg;
    logic signed [POS_W-1:0] cx_reg;
    logic signed [POS_W-1:0] cy_reg;
    logic signed [SW-1:0]    sx;
    logic signed [SW-1:0]    sy;
    logic signed [POS_W-1:0] px_next;
    logic signed [POS_W-1:0] py_next;
    logic signed [HEAD_W-1:0] hd_next;
    logic signed [POS_W-1:0] px_reg;
    logic signed [POS_W-1:0] py_reg;
    logic signed [HEAD_W-1:0] hd_reg;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SW-1:0] v);
        logic signed [POS_W-1:0] r;
        priority if (v > SW'(POS_MAX))
            r = POS_W'(POS_MAX);
        else if (v < SW'(POS_MIN))
            r = POS_W'(POS_MIN);
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

    assign p2_ready  = !p2_valid_reg || dn_ready;
    assign p1_ready  = !p1_valid_reg || p2_ready;
    assign up_ready  = p1_ready;
    assign dn_valid  = p2_valid_reg;
    assign pointer_x = px_reg;
    assign pointer_y = py_reg;
    assign heading   = hd_reg;

    // undo the half-turn fold and round Q.24 to Q.8, half up
    always_comb
    begin
        vx = up_data.flip ? (~up_data.rx + RW'(32769)) : (up_data.rx + RW'(32768));
        vy = up_data.flip ? (~up_data.ry + RW'(32769)) : (up_data.ry + RW'(32768));
        zr = up_data.z + ZW'(256);
        if (up_data.zero)
        begin
            offx_next = OW'(radius);
            offy_next = '0;
            head_next = '0;
        end
        else
        begin
            offx_next = vx[RW-1:OUT_SHIFT];
            offy_next = vy[RW-1:OUT_SHIFT];
            head_next = zr[ZW-1:HEAD_SHIFT];
        end
    end

    always_comb
    begin
        sx      = SW'(cx_reg) + SW'(offx_reg);
        sy      = SW'(cy_reg) + SW'(offy_reg);
        px_next = sat_pos(sx);
        py_next = sat_pos(sy);
        priority if (head_reg > HW'(HEAD_MAX))
            hd_next = HEAD_W'(HEAD_MAX);
        else if (head_reg < -HW'(HEAD_MAX))
            hd_next = -HEAD_W'(HEAD_MAX);
        else
            hd_next = head_reg[HEAD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            if (p1_ready)
            begin
                p1_valid_reg <= up_valid;
            end
            if (p2_ready)
            begin
                p2_valid_reg <= p1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_ready && up_valid)
        begin
            offx_reg <= offx_next;
            offy_reg <= offy_next;
            head_reg <= head_next;
            cx_reg   <= up_data.cx;
            cy_reg   <= up_data.cy;
        end
        if (p2_ready && p1_valid_reg)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
            hd_reg <= hd_next;
        end
    end

endmodule

`default_nettype wire

/* src/orbit_pointer_geometry_core.sv */
// Top level of the orbit pointer geometry block: radius register and CORDIC chain.
// Depends on opg_pkg, opg_in_if, opg_out_if, opg_front, opg_cell and opg_back.
`timescale 1ns / 1ps
`default_nettype none

// Each item carries a centre and a target point (signed Q15.8). The block returns
// the heading from centre to target in 1/128 degree (0 points to +x, a target
// straight left gives +180, goal equal to centre gives 0) and the pointer placed
// on a circle of the configured radius around the centre in that direction, each
// coordinate saturated to the Q15.8 range. The datapath is a chain of
// CORDIC_STAGES identical cells, each doing one vectoring decision and the
// matching rotation of the radius vector in the same cycle, framed by two front
// stages (difference, radius gain product, half-turn fold) and two back stages
// (rounding, offset add, saturation; the last one is the output register).
// One item enters per cycle while the output is not stalled; each item passes
// the front stages, the cell chain and the back stages in turn. Every stage has
// its own valid bit and hands over when the next one is free, so a stalled
// output only stops the stages behind it, and empty slots in the chain keep
// taking items. Write the radius register only while no item is in flight.
module orbit_pointer_geometry_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [opg_pkg::RAD_W-1:0]   cfg_wr_data,
    opg_in_if.sink                           in_ch,
    opg_out_if.source                        out_ch
);
    import opg_pkg::*;

    logic [RAD_W-1:0] radius_reg;

    // handshake links between stages: link 0 leaves the front end,
    // link NSTG enters the back end
    logic    link_valid [NSTG+1];
    logic    link_ready [NSTG+1];
    cordic_t link_data  [NSTG+1];

    // hold the radius; load it on a configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RAD_W'(RADIUS_RESET);
        end
        else if (cfg_wr_en)
        begin
            radius_reg <= cfg_wr_data;
        end
    end

    opg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_ch.valid),
        .up_ready (in_ch.ready),
        .center_x (in_ch.center_x),
        .center_y (in_ch.center_y),
        .goal_x   (in_ch.goal_x),
        .goal_y   (in_ch.goal_y),
        .radius   (radius_reg),
        .dn_valid (link_valid[0]),
        .dn_ready (link_ready[0]),
        .dn_data  (link_data[0])
    );

    // one cell per CORDIC iteration; the stage number sets shift and angle
    for (genvar k = 0; k < NSTG; k++)
    begin : g_cell
        opg_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .stage    (STG_W'(k)),
            .up_valid (link_valid[k]),
            .up_ready (link_ready[k]),
            .up_data  (link_data[k]),
            .dn_valid (link_valid[k+1]),
            .dn_ready (link_ready[k+1]),
            .dn_data  (link_data[k+1])
        );
    end

    // the user must keep the radius stable while items are in flight; the block does
    // not enforce it. The back end reads it directly for the goal-equals-centre case
    opg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (link_valid[NSTG]),
        .up_ready  (link_ready[NSTG]),
        .up_data   (link_data[NSTG]),
        .radius    (radius_reg),
        .dn_valid  (out_ch.valid),
        .dn_ready  (out_ch.ready),
        .pointer_x (out_ch.pointer_x),
        .pointer_y (out_ch.pointer_y),
        .heading   (out_ch.heading)
    );

endmodule

`default_nettype wire
